FILE: hw/rtl/nir_pkg.sv
// Shared widths, constants and status codes of the Newton inverse-root square root.
// No dependencies; used by the interfaces and the top-level module of the block.
package nir_pkg;
	localparam int RADICAND_W  = 32;
	localparam int ROOT_W      = 25;
	localparam int STATUS_W    = 2;
	localparam int ITER_W      = 7;
	localparam int TOL_W       = 24;
	localparam int MAX_ITER_DEF = 64;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16);

	// Estimate magnitude, multiplier operand and product widths
	localparam int Y_W     = 32;
	localparam int MCAND_W = 48;
	localparam int PROD_W  = MCAND_W + Y_W;
	localparam int T_W     = 41;
	localparam int SEED_W  = 42;
	localparam int D_W     = Y_W + 1;

	localparam logic [T_W-1:0]    TMAX      = T_W'(64'd1099511627776);
	localparam logic [T_W-1:0]    THREE_Q24 = T_W'(64'd50331648);
	localparam logic [ROOT_W-1:0] ROOT_MAX  = ROOT_W'(32'd16777216);
	localparam logic [SEED_W-1:0] SEED_NUM  = SEED_W'(64'd2199023255552);

	typedef enum logic [STATUS_W-1:0] {
		ST_CONVERGED = 2'd0,
		ST_DIVERGED  = 2'd1,
		ST_ZERO      = 2'd2,
		ST_LIMIT     = 2'd3
	} status_t;
endpackage

FILE: hw/rtl/nir_if.sv
// Request and result channels of the Newton inverse-root square root.
// Depends on nir_pkg for field widths.
interface nir_in_if;
	import nir_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [RADICAND_W-1:0] radicand;
	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

interface nir_out_if;
	import nir_pkg::*;
	logic                valid;
	logic                ready;
	logic [ROOT_W-1:0]   root;
	logic [STATUS_W-1:0] status;
	logic [ITER_W-1:0]   iterations;
	modport source (output valid, output root, output status, output iterations, input ready);
	modport sink   (input valid, input root, input status, input iterations, output ready);
endinterface

FILE: hw/rtl/newton_inverse_root_sqrt.sv
// Newton-Raphson square root through the inverse root, top level.
// Depends on nir_pkg, nir_if, nir_mul and nir_div.
//
//   channel  dir  payload                          handshake
//   in_ch    in   radicand[31:0]                   valid/ready
//   out_ch   out  root[24:0] status[1:0] iter[6:0] valid/ready
//   cfg      in   cfg_wdata[23:0] tolerance        cfg_we
//
// One request at a time; ready is high only while the block is idle.
// The seed comes from a serial division; each Newton step runs 3 serial multiplies
// plus start, done and bookkeeping states, and a final serial multiply forms the root.
// A zero radicand goes from idle straight to the done state. The result is held until taken.
// Reset restores tolerance to 16 and returns the controller to idle.
module newton_inverse_root_sqrt #(
	parameter int MAX_ITERATIONS = nir_pkg::MAX_ITER_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	nir_in_if.sink                    in_ch,
	nir_out_if.source                 out_ch,
	input  logic                      cfg_we,
	input  logic [nir_pkg::TOL_W-1:0] cfg_wdata
);
	import nir_pkg::*;

	localparam int NW = $clog2(MAX_ITERATIONS + 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SEED = 9'b000000010,
		S_MUL1 = 9'b000000100,
		S_MUL2 = 9'b000001000,
		S_MUL3 = 9'b000010000,
		S_DIFF = 9'b000100000,
		S_EVAL = 9'b001000000,
		S_ROOT = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q;

	logic [TOL_W-1:0]   tol_q;
	logic [Y_W-1:0]     s_q, ay_q, m_q;
	logic               ys_q, mneg_q, bneg_q, havep_q;
	logic [MCAND_W-1:0] q_q;
	logic [T_W-1:0]     ab_q;
	logic [D_W-1:0]     d_q, dprev_q;
	logic [NW-1:0]      n_q;
	logic [ROOT_W-1:0]  root_q;
	status_t            status_q;
	logic               mul_start_q, div_start_q;

	logic               mul_done, div_done;
	logic [PROD_W-1:0]  prod;
	logic [SEED_W-1:0]  quo;
	logic [MCAND_W-1:0] mcand;
	logic [PROD_W-25:0] t_full;
	logic [T_W-1:0]     t_c;
	logic [Y_W-1:0]     m_c;
	logic [D_W-1:0]     d_c;
	logic [NW-1:0]      n_next;
	logic [ROOT_W-1:0]  root_c;
	logic [PROD_W-25:0] r_full;

	always_comb begin
		case (state_q)
			S_MUL2:  mcand = q_q;
			S_MUL3:  mcand = MCAND_W'(ab_q);
			default: mcand = MCAND_W'(s_q);
		endcase
	end

	nir_mul #(.A_W(MCAND_W), .B_W(Y_W)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q),
		.mcand(mcand), .mplier(ay_q), .done(mul_done), .product(prod)
	);

	nir_div #(.N_W(SEED_W), .D_W(RADICAND_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q),
		.dividend(SEED_NUM), .divisor(s_q), .done(div_done), .quotient(quo)
	);

	// s*y*y in Q17.24, clamped
	assign t_full = prod[PROD_W-1:24];
	assign t_c    = (t_full > (PROD_W-24)'(TMAX)) ? TMAX : t_full[T_W-1:0];
	// |y|*|b| >> 25, clamped
	assign m_c    = (|prod[PROD_W-1:Y_W+25]) ? '1 : prod[Y_W+24:25];
	assign d_c    = (ys_q != mneg_q) ? ({1'b0, ay_q} + {1'b0, m_q})
		: (ay_q >= m_q) ? {1'b0, ay_q - m_q} : {1'b0, m_q - ay_q};
	assign n_next = n_q + 1'b1;
	assign r_full = prod[PROD_W-1:24];
	assign root_c = (r_full > (PROD_W-24)'(ROOT_MAX)) ? ROOT_MAX : r_full[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						if (in_ch.radicand == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q     <= S_SEED;
							div_start_q <= 1'b1;
						end
					end
				end
				S_SEED: begin
					if (div_done) begin
						state_q     <= S_MUL1;
						mul_start_q <= 1'b1;
					end
				end
				S_MUL1: begin
					if (mul_done) begin
						state_q     <= S_MUL2;
						mul_start_q <= 1'b1;
					end
				end
				S_MUL2: begin
					if (mul_done) begin
						state_q     <= S_MUL3;
						mul_start_q <= 1'b1;
					end
				end
				S_MUL3: begin
					if (mul_done) state_q <= S_DIFF;
				end
				S_DIFF: state_q <= S_EVAL;
				S_EVAL: begin
					if (havep_q && dprev_q < d_q) begin
						state_q <= S_DONE;
					end else if (d_q < D_W'(tol_q) || n_next == NW'(MAX_ITERATIONS)) begin
						if (!mneg_q && m_q != '0) begin
							state_q     <= S_ROOT;
							mul_start_q <= 1'b1;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q     <= S_MUL1;
						mul_start_q <= 1'b1;
					end
				end
				S_ROOT: begin
					if (mul_done) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_ch.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				s_q      <= in_ch.radicand;
				n_q      <= '0;
				havep_q  <= 1'b0;
				root_q   <= '0;
				status_q <= ST_ZERO;
			end
			S_SEED: begin
				if (div_done) begin
					ay_q <= (|quo[SEED_W-1:Y_W]) ? '1 : quo[Y_W-1:0];
					ys_q <= 1'b0;
				end
			end
			S_MUL1: begin
				if (mul_done) q_q <= prod[MCAND_W+15:16];
			end
			S_MUL2: begin
				if (mul_done) begin
					bneg_q <= t_c > THREE_Q24;
					ab_q   <= (t_c > THREE_Q24) ? t_c - THREE_Q24 : THREE_Q24 - t_c;
				end
			end
			S_MUL3: begin
				if (mul_done) begin
					m_q    <= m_c;
					mneg_q <= (ys_q != bneg_q) && (m_c != '0);
				end
			end
			S_DIFF: d_q <= d_c;
			S_EVAL: begin
				n_q <= n_next;
				if (havep_q && dprev_q < d_q) begin
					status_q <= ST_DIVERGED;
					root_q   <= '0;
				end else begin
					// adopt the new estimate
					ay_q     <= m_q;
					ys_q     <= mneg_q;
					dprev_q  <= d_q;
					havep_q  <= 1'b1;
					root_q   <= '0;
					status_q <= (d_q < D_W'(tol_q)) ? ST_CONVERGED : ST_LIMIT;
				end
			end
			S_ROOT: begin
				if (mul_done) root_q <= root_c;
			end
			default: ;
		endcase
	end

	assign in_ch.ready   = (state_q == S_IDLE);
	assign out_ch.valid  = (state_q == S_DONE);
	assign out_ch.root   = root_q;
	assign out_ch.status = status_q;

	generate
		if (NW > ITER_W) begin : g_sat
			assign out_ch.iterations = (n_q > NW'({ITER_W{1'b1}})) ? '1 : n_q[ITER_W-1:0];
		end else begin : g_ext
			assign out_ch.iterations = ITER_W'(n_q);
		end
	endgenerate

	a_zero_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.radicand == '0
		|=> out_ch.valid && out_ch.status == ST_ZERO && out_ch.root == '0)
		else $error("zero radicand not answered at once");
	a_div_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_DIVERGED |-> out_ch.root == '0)
		else $error("diverged result carries a root");
	a_iter_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> n_q <= NW'(MAX_ITERATIONS))
		else $error("iteration count past the limit");
	a_unit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mul_done && !div_done)
		else $error("arithmetic unit finished while idle");
endmodule

FILE: hw/rtl/nir_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Stand-alone; instantiated by newton_inverse_root_sqrt.
module nir_mul #(
	parameter int A_W = 48,
	parameter int B_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [A_W-1:0]   mcand,
	input  logic [B_W-1:0]   mplier,
	output logic             done,
	output logic [A_W+B_W-1:0] product
);
	localparam int CntW = $clog2(B_W + 1);

	logic [A_W+B_W-1:0] p_q;
	logic [A_W-1:0]     a_q;
	logic [CntW-1:0]    cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [A_W:0]       sum;

	assign sum = {1'b0, p_q[A_W+B_W-1:B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// add the multiplicand under the low bit, then shift one place right
	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{A_W{1'b0}}, mplier};
			a_q <= mcand;
		end else if (busy_q) begin
			p_q <= {sum, p_q[B_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = p_q;
endmodule

FILE: hw/rtl/nir_div.sv
// Restoring divider, one quotient bit per cycle, fixed dividend width.
// Stand-alone; instantiated by newton_inverse_root_sqrt for the seed.
module nir_div #(
	parameter int N_W = 42,
	parameter int D_W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N_W-1:0] quotient
);
	localparam int CntW = $clog2(N_W + 1);

	logic [N_W-1:0]  n_q;
	logic [N_W-1:0]  quo_q;
	logic [D_W-1:0]  r_q;
	logic [D_W-1:0]  dv_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [D_W:0]    r_sh;
	logic            fits;

	assign r_sh = {r_q, n_q[N_W-1]};
	assign fits = r_sh >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			dv_q  <= divisor;
			r_q   <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[N_W-2:0], 1'b0};
			r_q   <= fits ? D_W'(r_sh - {1'b0, dv_q}) : r_sh[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
